FILE: hdl/tpq_pkg.sv
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared types and constants for the three-level priority task queue.
// ----------------------------------------------------------------------------
package tpq_pkg;

  // Fixed payload widths of the channels
  localparam int CMD_W    = 2;
  localparam int PRIO_W   = 2;
  localparam int HANDLE_W = 16;
  localparam int NUMBER_W = 32;
  localparam int TOTAL_W  = 6;

  localparam int NUM_LEVELS = 3;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_GRAB  = 2'd1,
    CMD_SWAP  = 2'd2,
    CMD_FLUSH = 2'd3
  } cmd_t;

  // Per-level queue control from the arbiter to one level queue
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fifo_ctrl_t;

endpackage

FILE: hdl/tpq_if.sv
// ----------------------------------------------------------------------------
// tpq_in_if / tpq_out_if
// Valid/ready channels carrying commands in and results out.
// ----------------------------------------------------------------------------
interface tpq_in_if;
  logic                          valid;
  logic                          ready;
  logic [tpq_pkg::CMD_W-1:0]     cmd;
  logic [tpq_pkg::PRIO_W-1:0]    priority_req;
  logic [tpq_pkg::HANDLE_W-1:0]  task_handle;

  modport source (output valid, cmd, priority_req, task_handle, input ready);
  modport sink   (input valid, cmd, priority_req, task_handle, output ready);
endinterface

interface tpq_out_if;
  logic                          valid;
  logic                          ready;
  logic                          grant_valid;
  logic [tpq_pkg::HANDLE_W-1:0]  granted_handle;
  logic [tpq_pkg::NUMBER_W-1:0]  assigned_number;
  logic                          add_dropped;
  logic [tpq_pkg::TOTAL_W-1:0]   queued_total;

  modport source (output valid, grant_valid, granted_handle, assigned_number,
                  add_dropped, queued_total, input ready);
  modport sink   (input valid, grant_valid, granted_handle, assigned_number,
                  add_dropped, queued_total, output ready);
endinterface

FILE: hdl/tpq_level_fifo.sv
// ----------------------------------------------------------------------------
// tpq_level_fifo
// One priority level: circular buffer with a prefetched head entry, so the
// head is available from a register while the storage read stays registered.
// ----------------------------------------------------------------------------
module tpq_level_fifo #(
  parameter int DEPTH = 16,
  parameter int HW    = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tpq_pkg::fifo_ctrl_t          ctrl,
  input  logic [HW-1:0]                push_data,
  output logic [HW-1:0]                head_data,
  output logic [$clog2(DEPTH+1)-1:0]   fill
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [HW-1:0] mem [DEPTH];
  logic [HW-1:0] head_data_r;
  logic [AW-1:0] head_r, head_nxt, head_inc, tail;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW:0]   tail_sum;

  // Tail = head + fill, wrapped once
  always_comb begin
    tail_sum = {1'b0, fill_r} + (CW + 1)'(head_r);
    if (tail_sum >= (CW + 1)'(DEPTH)) begin
      tail = AW'(tail_sum - (CW + 1)'(DEPTH));
    end else begin
      tail = AW'(tail_sum);
    end
  end

  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);

  // Next pointer and count
  always_comb begin
    if (ctrl.clear) begin
      head_nxt = '0;
      fill_nxt = '0;
    end else begin
      head_nxt = ctrl.pop ? head_inc : head_r;
      fill_nxt = fill_r + CW'(ctrl.push) - CW'(ctrl.pop);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Storage write and head prefetch, bypassing a write to the new head
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[tail] <= push_data;
    end
    if (ctrl.push && tail == head_nxt) begin
      head_data_r <= push_data;
    end else begin
      head_data_r <= mem[head_nxt];
    end
  end

  assign head_data = head_data_r;
  assign fill      = fill_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH))
    else $error("level fill above depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.pop && !ctrl.push && fill_r == '0))
    else $error("pop from empty level");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.push && !ctrl.pop && fill_r == CW'(DEPTH)))
    else $error("push into full level");

endmodule

FILE: hdl/three_level_priority_task_queue.sv
// ----------------------------------------------------------------------------
// three_level_priority_task_queue
// Strict-priority task queue with three FIFO levels: add, grab, swap, flush.
// ----------------------------------------------------------------------------
//   channel  dir  handshake              payload
//   in_ch    in   valid/ready (sink)     cmd, priority_req, task_handle
//   out_ch   out  valid/ready (source)   grant_valid, granted_handle,
//                                        assigned_number, add_dropped,
//                                        queued_total
//
// One command per cycle sustained while out_ch is not stalled; an accepted
// command passes the input register, then the queue update and result register.
// The per-level pointer/fill update is the feedback loop that sets the rate.
// Reset (rst_n low, synchronous) empties all levels and zeroes the task
// number; queue storage is not cleared.
// A stalled result holds the output register; one more item waits in the
// input register before in_ch.ready drops.
// ----------------------------------------------------------------------------
module three_level_priority_task_queue #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  tpq_in_if.sink     in_ch,
  tpq_out_if.source  out_ch
);

  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int NL  = tpq_pkg::NUM_LEVELS;
  localparam int SW  = CW + 2;
  localparam int TW  = tpq_pkg::TOTAL_W;

  // Input register
  logic                          in_valid_r;
  tpq_pkg::cmd_t                 cmd_r;
  logic [tpq_pkg::PRIO_W-1:0]    prio_r;
  logic [HANDLE_WIDTH-1:0]       handle_r;

  // Result register
  logic                          out_valid_r;
  logic                          grant_valid_r;
  logic [tpq_pkg::HANDLE_W-1:0]  granted_handle_r;
  logic [tpq_pkg::NUMBER_W-1:0]  number_r;
  logic                          dropped_r;
  logic [TW-1:0]                 total_r;

  logic [tpq_pkg::NUMBER_W-1:0]  seq_r;

  logic                          fire;
  logic                          is_add, is_grab;
  tpq_pkg::fifo_ctrl_t           ctrl [NL];
  logic [HANDLE_WIDTH-1:0]       head_data [NL];
  logic [CW-1:0]                 fill [NL];
  logic [CW-1:0]                 fill_after [NL];
  logic [NL-1:0]                 push, avail, pop;
  logic                          grant_valid_nxt;
  logic [HANDLE_WIDTH-1:0]       grant_handle_nxt;
  logic [SW-1:0]                 total_sum;
  logic [TW-1:0]                 total_nxt;

  assign fire        = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      cmd_r    <= tpq_pkg::cmd_t'(in_ch.cmd);
      prio_r   <= in_ch.priority_req;
      handle_r <= HANDLE_WIDTH'(in_ch.task_handle);
    end
  end

  // Command decode and per-level push
  assign is_add  = (cmd_r == tpq_pkg::CMD_ADD) || (cmd_r == tpq_pkg::CMD_SWAP);
  assign is_grab = (cmd_r == tpq_pkg::CMD_GRAB) || (cmd_r == tpq_pkg::CMD_SWAP);

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      push[l]  = fire && is_add && (prio_r == tpq_pkg::PRIO_W'(l)) &&
                 (fill[l] != CW'(QUEUE_DEPTH));
      avail[l] = (fill[l] != '0) || push[l];
    end
  end

  // Grab from the highest level holding an entry after the add
  always_comb begin
    pop              = '0;
    grant_valid_nxt  = 1'b0;
    grant_handle_nxt = '0;
    if (fire && is_grab) begin
      priority if (avail[0]) begin
        pop[0]           = 1'b1;
        grant_valid_nxt  = 1'b1;
        grant_handle_nxt = (fill[0] == '0) ? handle_r : head_data[0];
      end else if (avail[1]) begin
        pop[1]           = 1'b1;
        grant_valid_nxt  = 1'b1;
        grant_handle_nxt = (fill[1] == '0) ? handle_r : head_data[1];
      end else if (avail[2]) begin
        pop[2]           = 1'b1;
        grant_valid_nxt  = 1'b1;
        grant_handle_nxt = (fill[2] == '0) ? handle_r : head_data[2];
      end
    end
  end

  // Level queues
  for (genvar g = 0; g < NL; g++) begin : g_level
    assign ctrl[g].push  = push[g];
    assign ctrl[g].pop   = pop[g];
    assign ctrl[g].clear = fire && (cmd_r == tpq_pkg::CMD_FLUSH);

    tpq_level_fifo #(
      .DEPTH (QUEUE_DEPTH),
      .HW    (HANDLE_WIDTH)
    ) u_level (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl[g]),
      .push_data (handle_r),
      .head_data (head_data[g]),
      .fill      (fill[g])
    );
  end

  // Total after the step, saturated to the field
  always_comb begin
    total_sum = '0;
    for (int l = 0; l < NL; l++) begin
      if (cmd_r == tpq_pkg::CMD_FLUSH) begin
        fill_after[l] = '0;
      end else begin
        fill_after[l] = fill[l] + CW'(push[l]) - CW'(pop[l]);
      end
      total_sum = total_sum + SW'(fill_after[l]);
    end
    if (total_sum > SW'((1 << TW) - 1)) begin
      total_nxt = '1;
    end else begin
      total_nxt = TW'(total_sum);
    end
  end

  // Task number and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (fire && is_add) begin
        seq_r <= seq_r + tpq_pkg::NUMBER_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      grant_valid_r    <= grant_valid_nxt;
      granted_handle_r <= tpq_pkg::HANDLE_W'(grant_handle_nxt);
      number_r         <= is_add ? seq_r : '0;
      dropped_r        <= is_add && (push == '0);
      total_r          <= total_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.grant_valid     = grant_valid_r;
  assign out_ch.granted_handle  = granted_handle_r;
  assign out_ch.assigned_number = number_r;
  assign out_ch.add_dropped     = dropped_r;
  assign out_ch.queued_total    = total_r;

  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cmd_r == tpq_pkg::CMD_FLUSH |=>
      out_ch.queued_total == '0 && !out_ch.grant_valid)
    else $error("flush left entries or granted a task");

  a_grab_no_number: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cmd_r == tpq_pkg::CMD_GRAB |=>
      out_ch.assigned_number == '0 && !out_ch.add_dropped)
    else $error("grab reported add fields");

  a_seq_advance: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_add |=> seq_r == $past(seq_r) + tpq_pkg::NUMBER_W'(1))
    else $error("task number did not advance on add");

  a_seq_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(fire && is_add) |=> $stable(seq_r))
    else $error("task number moved without add");

endmodule

FILE: verif/tb_three_level_priority_task_queue.sv
// ----------------------------------------------------------------------------
// tb_three_level_priority_task_queue
// Drives add/grab/swap/flush commands into the priority task queue and checks
// every result against a cycle-free model of the three FIFO levels. A short
// table covers empty grabs, invalid priority, full levels and swap; random
// phases then fill and drain the levels under bursty input and output stalls.
// ----------------------------------------------------------------------------
module tb_three_level_priority_task_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVEL_DEPTH  = 16;
  localparam int RANDOM_ITEMS = 1400;

  // One result item as the block reports it
  typedef struct packed {
    logic                         grant_valid;
    logic [tpq_pkg::HANDLE_W-1:0] granted_handle;
    logic [tpq_pkg::NUMBER_W-1:0] assigned_number;
    logic                         add_dropped;
    logic [tpq_pkg::TOTAL_W-1:0]  queued_total;
  } task_result_t;

  // Directed row: reps > 1 repeats the command with an incrementing handle
  typedef struct {
    tpq_pkg::cmd_t                cmd;
    logic [tpq_pkg::PRIO_W-1:0]   prio;
    logic [tpq_pkg::HANDLE_W-1:0] handle;
    int                           reps;
    bit                           typed;
    task_result_t                 want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  tpq_in_if  in_ch ();
  tpq_out_if out_ch ();

  three_level_priority_task_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the three levels
  logic [tpq_pkg::HANDLE_W-1:0] level_store [tpq_pkg::NUM_LEVELS][LEVEL_DEPTH];
  int                           level_head  [tpq_pkg::NUM_LEVELS];
  int                           level_fill  [tpq_pkg::NUM_LEVELS];
  logic [tpq_pkg::NUMBER_W-1:0] next_task_number;

  task_result_t pending_results [$];
  int           fail_count = 0;
  int           burst_left;

  // Receiver stall pattern state
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;

  // Sequence wrap of the task number needs 2^32 adds and is out of reach here.
  stim_row_t directed_rows [] = '{
    // grab and flush after reset
    '{tpq_pkg::CMD_GRAB,  2'd0, 16'h0000, 1,  1'b1,
      '{1'b0, 16'h0000, 32'd0,  1'b0, 6'd0}},
    '{tpq_pkg::CMD_FLUSH, 2'd0, 16'h0000, 1,  1'b1,
      '{1'b0, 16'h0000, 32'd0,  1'b0, 6'd0}},
    // one add per level, then the out-of-range priority
    '{tpq_pkg::CMD_ADD,   2'd0, 16'hFFFF, 1,  1'b1,
      '{1'b0, 16'h0000, 32'd0,  1'b0, 6'd1}},
    '{tpq_pkg::CMD_ADD,   2'd1, 16'h0000, 1,  1'b1,
      '{1'b0, 16'h0000, 32'd1,  1'b0, 6'd2}},
    '{tpq_pkg::CMD_ADD,   2'd2, 16'hAAAA, 1,  1'b1,
      '{1'b0, 16'h0000, 32'd2,  1'b0, 6'd3}},
    '{tpq_pkg::CMD_ADD,   2'd3, 16'h5555, 1,  1'b1,
      '{1'b0, 16'h0000, 32'd3,  1'b1, 6'd3}},
    // drain in strict priority order
    '{tpq_pkg::CMD_GRAB,  2'd0, 16'h0000, 1,  1'b1,
      '{1'b1, 16'hFFFF, 32'd0,  1'b0, 6'd2}},
    '{tpq_pkg::CMD_GRAB,  2'd0, 16'h0000, 1,  1'b1,
      '{1'b1, 16'h0000, 32'd0,  1'b0, 6'd1}},
    '{tpq_pkg::CMD_GRAB,  2'd0, 16'h0000, 1,  1'b1,
      '{1'b1, 16'hAAAA, 32'd0,  1'b0, 6'd0}},
    // swap returns its own handle; swap with bad priority grabs nothing
    '{tpq_pkg::CMD_SWAP,  2'd2, 16'h1234, 1,  1'b1,
      '{1'b1, 16'h1234, 32'd4,  1'b0, 6'd0}},
    '{tpq_pkg::CMD_SWAP,  2'd3, 16'h4321, 1,  1'b1,
      '{1'b0, 16'h0000, 32'd5,  1'b1, 6'd0}},
    // fill the medium level, then add and swap against the full level
    '{tpq_pkg::CMD_ADD,   2'd1, 16'h0F0F, 16, 1'b0, '0},
    '{tpq_pkg::CMD_ADD,   2'd1, 16'hF0F0, 1,  1'b1,
      '{1'b0, 16'h0000, 32'd22, 1'b1, 6'd16}},
    '{tpq_pkg::CMD_SWAP,  2'd1, 16'h00FF, 1,  1'b1,
      '{1'b1, 16'h0F0F, 32'd23, 1'b1, 6'd15}},
    '{tpq_pkg::CMD_SWAP,  2'd0, 16'h7FFE, 1,  1'b0, '0},
    // flush keeps the task number, then the levels are empty
    '{tpq_pkg::CMD_FLUSH, 2'd0, 16'h0000, 1,  1'b1,
      '{1'b0, 16'h0000, 32'd0,  1'b0, 6'd0}},
    '{tpq_pkg::CMD_GRAB,  2'd0, 16'h0000, 1,  1'b1,
      '{1'b0, 16'h0000, 32'd0,  1'b0, 6'd0}}
  };

  // Clock: 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Apply one command to the shadow levels and return its result
  function automatic task_result_t apply_command(
      input tpq_pkg::cmd_t                c,
      input logic [tpq_pkg::PRIO_W-1:0]   p,
      input logic [tpq_pkg::HANDLE_W-1:0] h);
    task_result_t r;
    bit           taken;
    int           total;
    r = '0;
    taken = 1'b0;
    if (c == tpq_pkg::CMD_ADD || c == tpq_pkg::CMD_SWAP) begin
      r.assigned_number = next_task_number;
      next_task_number = next_task_number + 1;
      if (p < tpq_pkg::NUM_LEVELS && level_fill[p] < LEVEL_DEPTH) begin
        level_store[p][(level_head[p] + level_fill[p]) % LEVEL_DEPTH] = h;
        level_fill[p]++;
      end else begin
        r.add_dropped = 1'b1;
      end
    end
    if (c == tpq_pkg::CMD_GRAB || c == tpq_pkg::CMD_SWAP) begin
      for (int lv = 0; lv < tpq_pkg::NUM_LEVELS; lv++) begin
        if (!taken && level_fill[lv] > 0) begin
          taken = 1'b1;
          r.grant_valid = 1'b1;
          r.granted_handle = level_store[lv][level_head[lv]];
          level_head[lv] = (level_head[lv] + 1) % LEVEL_DEPTH;
          level_fill[lv]--;
        end
      end
    end
    if (c == tpq_pkg::CMD_FLUSH) begin
      for (int lv = 0; lv < tpq_pkg::NUM_LEVELS; lv++) begin
        level_head[lv] = 0;
        level_fill[lv] = 0;
      end
    end
    total = level_fill[0] + level_fill[1] + level_fill[2];
    r.queued_total = (total > 63) ? 6'd63 : tpq_pkg::TOTAL_W'(total);
    return r;
  endfunction

  // Sender pacing: bursts of random length separated by random gaps
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 6);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  // Present one item and hold it until accepted; record its expected result
  task automatic send_item(input tpq_pkg::cmd_t c,
                           input logic [tpq_pkg::PRIO_W-1:0] p,
                           input logic [tpq_pkg::HANDLE_W-1:0] h, input bit typed,
                           input task_result_t want);
    task_result_t predicted;
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= c;
    in_ch.priority_req <= p;
    in_ch.task_handle  <= h;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = apply_command(c, p, h);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Receiver: ready pattern changes mode every so often
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 4);
      stall_left = (stall_mode == 4) ? $urandom_range(2, 12) : $urandom_range(20, 80);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 9) < 7);
      2: out_ch.ready <= ($urandom_range(0, 9) < 3);
      3: out_ch.ready <= ((stall_tick % 4) != 0);
      default: out_ch.ready <= 1'b0;
    endcase
  end

  // Result checker
  always @(posedge clk) begin
    task_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: total %0d", out_ch.queued_total);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.grant_valid !== want.grant_valid) begin
          $error("grant_valid: expected %0b, actual %0b", want.grant_valid, out_ch.grant_valid);
          fail_count++;
        end
        if (out_ch.granted_handle !== want.granted_handle) begin
          $error("granted_handle: expected %h, actual %h",
                 want.granted_handle, out_ch.granted_handle);
          fail_count++;
        end
        if (out_ch.assigned_number !== want.assigned_number) begin
          $error("assigned_number: expected %0d, actual %0d",
                 want.assigned_number, out_ch.assigned_number);
          fail_count++;
        end
        if (out_ch.add_dropped !== want.add_dropped) begin
          $error("add_dropped: expected %0b, actual %0b", want.add_dropped, out_ch.add_dropped);
          fail_count++;
        end
        if (out_ch.queued_total !== want.queued_total) begin
          $error("queued_total: expected %0d, actual %0d",
                 want.queued_total, out_ch.queued_total);
          fail_count++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    int                           phase;
    int                           focus;
    int                           pick;
    tpq_pkg::cmd_t                c;
    logic [tpq_pkg::PRIO_W-1:0]   p;
    logic [tpq_pkg::HANDLE_W-1:0] h;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = tpq_pkg::CMD_ADD;
    in_ch.priority_req = '0;
    in_ch.task_handle  = '0;
    burst_left         = 0;
    next_task_number   = '0;
    focus              = 0;
    for (int lv = 0; lv < tpq_pkg::NUM_LEVELS; lv++) begin
      level_head[lv] = 0;
      level_fill[lv] = 0;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (directed_rows[i]) begin
      for (int r = 0; r < directed_rows[i].reps; r++) begin
        pace_sender();
        send_item(directed_rows[i].cmd, directed_rows[i].prio,
                  directed_rows[i].handle + tpq_pkg::HANDLE_W'(r),
                  directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases: fill-heavy, drain-heavy and balanced, each around one level
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 120 == 0) focus = $urandom_range(0, tpq_pkg::NUM_LEVELS - 1);
      phase = (i / 120) % 3;
      pick = $urandom_range(0, 99);
      case (phase)
        0: c = (pick < 55) ? tpq_pkg::CMD_ADD : (pick < 70) ? tpq_pkg::CMD_SWAP :
               (pick < 97) ? tpq_pkg::CMD_GRAB : tpq_pkg::CMD_FLUSH;
        1: c = (pick < 20) ? tpq_pkg::CMD_ADD : (pick < 35) ? tpq_pkg::CMD_SWAP :
               (pick < 98) ? tpq_pkg::CMD_GRAB : tpq_pkg::CMD_FLUSH;
        default: c = (pick < 35) ? tpq_pkg::CMD_ADD : (pick < 60) ? tpq_pkg::CMD_SWAP :
                     (pick < 97) ? tpq_pkg::CMD_GRAB : tpq_pkg::CMD_FLUSH;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 70) p = tpq_pkg::PRIO_W'(focus);
      else if (pick < 94) p = tpq_pkg::PRIO_W'($urandom_range(0, tpq_pkg::NUM_LEVELS - 1));
      else p = 2'd3;
      pick = $urandom_range(0, 9);
      h = (pick == 0) ? '0 : (pick == 1) ? '1 : tpq_pkg::HANDLE_W'($urandom);
      pace_sender();
      send_item(c, p, h, 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    // Drain, then wait for any stray result
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_three_level_priority_task_queue: PASS");
    end else begin
      $display("tb_three_level_priority_task_queue: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("tb_three_level_priority_task_queue: FAIL");
    $finish;
  end

endmodule
